@@ rtl/pcu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcu_pkg
// Shared types and constants of the packed coefficient unpack unit.
// ----------------------------------------------------------------------------
package pcu_pkg;
    localparam int MAX_FIELD_BITS = 191;
    localparam int WORK_BITS      = 256;

    localparam logic [1:0] REG_COEFF_BITS  = 2'd0;
    localparam logic [1:0] REG_MODULUS     = 2'd1;
    localparam logic [1:0] REG_COEFF_COUNT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RED,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic bit_in;
        logic busy;
    } t_red_ctl;
endpackage
`default_nettype wire

@@ rtl/packed_coeff_unpack_mod_reduce_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// packed_coeff_unpack_mod_reduce_unit
// Cuts a little-endian limb stream into fields and reduces each field.
// ----------------------------------------------------------------------------
// Each field is reduced in the single, shared bit-serial reducer (S_RED),
// then presented in S_OUT; a limb is accepted in S_IDLE before its fields.
// The reducer sets throughput: one field bit per cycle unless output stalls.
// Reset (synchronous, active low) restores register defaults and empties the
// bit buffer and the coefficient index.
module packed_coeff_unpack_mod_reduce_unit
    import pcu_pkg::*;
#(
    parameter int LIMB_BITS   = 64,
    parameter int COUNT_WIDTH = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // limb
    input  wire         s_axis_tuser,   // first_limb
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // coeff
    output logic        m_axis_tlast,   // run_end
    output logic        m_axis_tuser    // poly_end
);
    t_state r_state, n_state;
    logic [7:0]             r_cbits;
    logic [63:0]            r_mod;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [WORK_BITS-1:0]   r_work;
    logic [8:0]             r_total;
    logic [7:0]             r_nb;
    logic [COUNT_WIDTH-1:0] r_idx;
    logic [7:0]             r_k;
    logic [63:0]            r_coeff;
    logic                   r_last, r_pend;
    logic [7:0]             w_w;
    logic [63:0]            w_rem;
    logic [WORK_BITS-1:0]   w_limb_sh;
    logic [COUNT_WIDTH-1:0] w_idx1;
    logic                   w_more;
    t_red_ctl               w_ctl;
    logic                   w_acc;
    logic                   w_take;
    logic [7:0]             w_nb0;
    logic [8:0]             w_total0;
    logic                   w_out_go;

    assign w_w = (r_cbits == 8'd0) ? 8'd1 :
                 (r_cbits > 8'(MAX_FIELD_BITS)) ? 8'(MAX_FIELD_BITS) : r_cbits;
    assign w_out_go = !m_axis_tvalid || m_axis_tready;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_go;
    assign w_nb0 = s_axis_tuser ? 8'd0 : r_nb;
    assign w_total0 = 9'(w_nb0) + 9'(LIMB_BITS);
    assign w_take = s_axis_tuser ? (r_count != '0) : (r_idx < r_count);
    assign w_limb_sh = {{(WORK_BITS-LIMB_BITS){1'b0}}, s_axis_tdata[LIMB_BITS-1:0]}
                       << w_nb0;
    assign w_idx1 = r_idx + 1'b1;
    assign w_more = (r_total - 9'(w_w) >= 9'(w_w)) && (w_idx1 < r_count);

    assign w_ctl.start  = (r_state == S_IDLE) || ((r_state == S_OUT) && w_out_go);
    assign w_ctl.busy   = (r_state == S_RED);
    assign w_ctl.bit_in = r_work[r_k - 8'd1];

    pcu_reducer u_red (
        .i_clk    (i_clk),
        .i_modulus(r_mod),
        .i_ctl    (w_ctl),
        .o_rem    (w_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && w_take && (w_total0 >= 9'(w_w))) begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (r_k == 8'd1) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_go) begin
                    n_state = w_more ? S_RED : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cbits <= 8'd64;
            r_mod   <= 64'd2;
            r_count <= COUNT_WIDTH'(1);
            r_nb    <= '0;
            r_idx   <= '0;
            r_work  <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && w_out_go) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COEFF_BITS:  r_cbits <= i_cfg_data[7:0];
                    REG_MODULUS:     r_mod   <= i_cfg_data;
                    REG_COEFF_COUNT: r_count <= i_cfg_data[COUNT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_cfg_we && (i_cfg_index == REG_COEFF_BITS)) begin
                r_nb   <= '0;
                r_work <= '0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (w_acc) begin
                            if (s_axis_tuser) begin
                                r_idx <= '0;
                            end
                            if (w_take) begin
                                r_work  <= (s_axis_tuser ? '0 : r_work) | w_limb_sh;
                                r_total <= w_total0;
                                r_nb    <= 8'(w_total0);
                                r_k     <= w_w;
                            end else if (s_axis_tuser) begin
                                r_work <= '0;
                                r_nb   <= '0;
                            end
                        end
                    end
                    S_RED: begin
                        r_k <= r_k - 8'd1;
                    end
                    S_OUT: begin
                        if (w_out_go) begin
                            r_coeff <= w_rem;
                            r_last  <= !w_more;
                            r_pend  <= (w_idx1 == r_count);
                            r_idx   <= w_idx1;
                            r_total <= r_total - 9'(w_w);
                            r_k     <= w_w;
                            if (w_idx1 >= r_count) begin
                                r_work <= '0;
                                r_nb   <= '0;
                            end else begin
                                r_work <= r_work >> w_w;
                                r_nb   <= 8'(r_total - 9'(w_w));
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tdata = r_coeff;
    assign m_axis_tlast = r_last;
    assign m_axis_tuser = r_pend;
endmodule
`default_nettype wire

@@ rtl/pcu_reducer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcu_reducer
// Bit-serial modular reduction: one field bit per busy cycle, MSB first.
// ----------------------------------------------------------------------------
module pcu_reducer
    import pcu_pkg::*;
(
    input  wire         i_clk,
    input  wire  [63:0] i_modulus,
    input  t_red_ctl    i_ctl,
    output logic [63:0] o_rem
);
    logic [63:0] r_rem;
    logic [64:0] w_t;
    logic [64:0] w_sub;

    assign w_t   = {r_rem, i_ctl.bit_in};
    assign w_sub = w_t - {1'b0, i_modulus};

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
        end else if (i_ctl.busy) begin
            if (w_t[64] || (w_t[63:0] >= i_modulus)) begin
                r_rem <= w_sub[63:0];
            end else begin
                r_rem <= w_t[63:0];
            end
        end
    end

    assign o_rem = r_rem;
endmodule
`default_nettype wire

@@ verif/pcu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcu_checker
// Watches the configuration port and both streams of the unpack unit,
// predicts each coefficient from the accepted limbs and compares the results.
// ----------------------------------------------------------------------------
module pcu_checker
    import pcu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [63:0] i_in_limb,
    input  wire         i_in_first,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [63:0] i_out_coeff,
    input  wire         i_out_run_end,
    input  wire         i_out_poly_end,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_coeff_seen
);
    typedef struct packed {
        logic [63:0] coeff;
        logic        run_end;
        logic        poly_end;
    } t_coeff_item;

    logic [7:0]   field_width;
    logic [63:0]  mod_value;
    logic [23:0]  poly_len;
    logic [191:0] pend_bits;
    int           pend_count;
    logic [23:0]  coeff_done;
    t_coeff_item  coeff_queue[$];

    function automatic logic [63:0] mod_reduce(logic [255:0] bits, int pos, int w);
        logic [63:0] r;
        logic [63:0] t;
        logic        carry;
        r = '0;
        for (int k = w - 1; k >= 0; k--) begin
            carry = r[63];
            t = {r[62:0], bits[(pos + k) % 256]};
            if (carry || t >= mod_value) begin
                t = t - mod_value;
            end
            r = t;
        end
        return r;
    endfunction

    task automatic unpack_limb(logic [63:0] limb, logic first);
        logic [255:0] work;
        int           w;
        int           total;
        int           pos;
        t_coeff_item  item;
        int           made;
        if (first) begin
            pend_bits = '0;
            pend_count = 0;
            coeff_done = '0;
        end
        if (coeff_done >= poly_len) begin
            return;
        end
        w = (field_width == 0) ? 1 : (field_width > MAX_FIELD_BITS ? MAX_FIELD_BITS
                                                                    : int'(field_width));
        work = {64'd0, pend_bits};
        work = work | (256'(limb) << pend_count);
        total = pend_count + 64;
        pos = 0;
        made = 0;
        while (total - pos >= w && coeff_done < poly_len) begin
            item.coeff = mod_reduce(work, pos, w);
            item.run_end = 1'b0;
            coeff_done++;
            item.poly_end = (coeff_done == poly_len);
            coeff_queue.push_back(item);
            pos += w;
            made++;
        end
        if (made > 0) begin
            coeff_queue[coeff_queue.size() - 1].run_end = 1'b1;
        end
        if (coeff_done >= poly_len) begin
            pend_bits = '0;
            pend_count = 0;
        end else begin
            pend_bits = 192'(work >> pos);
            pend_count = total - pos;
        end
    endtask

    assign o_pending = coeff_queue.size();

    always @(posedge i_clk) begin
        t_coeff_item want;
        if (!i_rst_n) begin
            field_width <= 8'd64;
            mod_value <= 64'd2;
            poly_len <= 24'd1;
            pend_bits = '0;
            pend_count = 0;
            coeff_done = '0;
            coeff_queue.delete();
            o_fail_count <= 0;
            o_coeff_seen <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_coeff_seen <= o_coeff_seen + 1;
                if (coeff_queue.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected coefficient %h", i_out_coeff);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = coeff_queue.pop_front();
                    if (want.coeff !== i_out_coeff || want.run_end !== i_out_run_end
                            || want.poly_end !== i_out_poly_end) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.coeff, want.run_end, want.poly_end,
                                     i_out_coeff, i_out_run_end, i_out_poly_end);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                unpack_limb(i_in_limb, i_in_first);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COEFF_BITS: begin
                        field_width <= i_cfg_data[7:0];
                        pend_bits = '0;
                        pend_count = 0;
                    end
                    REG_MODULUS: mod_value <= i_cfg_data;
                    REG_COEFF_COUNT: poly_len <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ verif/tb_packed_coeff_unpack_mod_reduce_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_coeff_unpack_mod_reduce_unit
// Drives limb polynomials under several field widths, moduli and counts,
// with random source gaps and sink stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_packed_coeff_unpack_mod_reduce_unit;
    import pcu_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    int          coeff_seen;
    int          limbs_sent;
    int          idle_cycles;
    int          stall_mode;

    packed_coeff_unpack_mod_reduce_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    pcu_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_limb(s_axis_tdata), .i_in_first(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_coeff(m_axis_tdata), .i_out_run_end(m_axis_tlast),
        .i_out_poly_end(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_coeff_seen(coeff_seen)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("packed_coeff_unpack_mod_reduce_unit test failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) begin
            stall_mode <= $urandom_range(0, 2);
        end
    end

    task automatic write_reg(logic [1:0] index, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_limb(logic [63:0] limb, logic first);
        if ($urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= limb;
        s_axis_tuser <= first;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        limbs_sent++;
    endtask

    function automatic logic [63:0] random_limb();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Waits for the outstanding coefficients, then for the reducer to drain
    // work that produces nothing, before the registers are touched.
    task automatic drain_unit();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (1000) @(negedge i_clk);
    endtask

    task automatic set_mode(logic [7:0] width, logic [63:0] modv, logic [23:0] count);
        drain_unit();
        write_reg(REG_COEFF_BITS, 64'(width));
        write_reg(REG_MODULUS, modv);
        write_reg(REG_COEFF_COUNT, 64'(count));
    endtask

    task automatic send_poly(int limbs);
        for (int k = 0; k < limbs; k++) begin
            send_limb(random_limb(), k == 0);
        end
    endtask

    initial begin
        logic [7:0]  width;
        logic [63:0] modv;
        int          count;
        int          limbs;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_COEFF_BITS;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b1;
        stall_mode = 0;
        limbs_sent = 0;
        idle_cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, then the edge cases of each register.
        send_limb('1, 1'b1);
        send_limb('1, 1'b0);
        set_mode(8'd1, 64'd0, 24'd70);
        send_poly(2);
        set_mode(8'd191, '1, 24'd3);
        send_poly(4);
        send_limb('1, 1'b1);
        send_limb('1, 1'b0);
        send_limb('1, 1'b0);
        set_mode(8'd0, 64'd1, 24'd5);
        send_poly(1);
        set_mode(8'd255, 64'h8000_0000_0000_0001, 24'd2);
        send_poly(6);
        set_mode(8'd7, 64'd13, 24'd0);
        send_poly(2);
        set_mode(8'd65, 64'h7FFF_FFFF_FFFF_FFFF, 24'hFF_FFFF);
        send_poly(3);
        drain_unit();
        write_reg(2'd3, '1);
        write_reg(REG_COEFF_BITS, 64'd33);
        send_limb({$urandom(), $urandom()}, 1'b0);
        send_limb({$urandom(), $urandom()}, 1'b0);

        while (limbs_sent < 370) begin
            case ($urandom_range(0, 3))
                0: width = 8'($urandom_range(1, 16));
                1: width = 8'($urandom_range(17, 80));
                2: width = 8'($urandom_range(81, 191));
                default: width = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 4))
                0: modv = 64'($urandom_range(0, 300));
                1: modv = '1 - 64'($urandom_range(0, 5));
                default: modv = {$urandom(), $urandom()};
            endcase
            count = $urandom_range(1, 40);
            set_mode(width, modv, 24'(count));
            for (int p = 0; p < 3; p++) begin
                limbs = (count * ((width == 0) ? 1 : int'(width))) / 64
                        + $urandom_range(0, 2);
                if (limbs > 30) limbs = 30;
                send_poly(limbs + 1);
            end
        end

        drain_unit();
        $display("Sent %0d limbs over many width, modulus and count settings;", limbs_sent);
        $display("%0d coefficients were compared.", coeff_seen);
        if (fail_count == 0) begin
            $display("packed_coeff_unpack_mod_reduce_unit test passed");
        end else begin
            $display("packed_coeff_unpack_mod_reduce_unit test failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/pcu_pkg.sv
rtl/pcu_reducer.sv
rtl/packed_coeff_unpack_mod_reduce_unit.sv
verif/pcu_checker.sv
verif/tb_packed_coeff_unpack_mod_reduce_unit.sv
